// ----- rtl/swad_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swad_pkg
// Shared types for the sliding window anagram detector: operation codes and
// the command bundle that drives the symbol count store.
// ----------------------------------------------------------------------------
package swad_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_IDLE    = 2'd3
  } op_t;

  // Per-cycle commands to the count store.
  typedef struct packed {
    logic rd_a;  // read port A (symbol entering)
    logic rd_b;  // read port B (symbol leaving)
    logic wr;    // write one entry
    logic clr;   // empty the whole store
  } ram_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/sliding_window_anagram_detector_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_anagram_detector_unit
// Finds permutations of a pattern in a byte stream with a pattern histogram,
// a sliding window histogram and a running count of differing symbols.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word                                    Handshake
//  in_      input      operation, symbol                       in_valid / in_stall
//  out_     output     window_match, found, rejected           out_valid / out_stall
//
//  A word passes the entering step, the leaving step and the output register;
//  it leaves the entering step only once the leaving step is empty. This is
//  set by the single write port of the count memory, which takes two
//  read-modify-writes per text word (entering symbol, then leaving symbol).
//  Synchronous reset clears control state and the count valid bits; no
//  clearing pass is needed. A stalled result holds in the output register
//  while the next word is still taken and worked up to its final step.
// ----------------------------------------------------------------------------
module sliding_window_anagram_detector_unit #(
  parameter int MAX_PATTERN  = 1024,
  parameter int SYMBOL_COUNT = 256
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [1:0]  in_operation,
  input  wire [7:0]  in_symbol,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_window_match,
  output logic       out_found,
  output logic       out_rejected
);

  localparam int SYM_W   = $clog2(SYMBOL_COUNT);
  localparam int CNT_W   = $clog2(MAX_PATTERN + 2);
  localparam int PTR_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int DIFF_W  = $clog2(SYMBOL_COUNT + 1);
  localparam int ENTRY_W = 2 * CNT_W;

  // Reduces a byte modulo SYMBOL_COUNT by conditional subtraction.
  function automatic logic [SYM_W-1:0] reduce_sym(input logic [7:0] v);
    logic [15:0] r;
    r = {8'd0, v};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (16'(SYMBOL_COUNT) << k)) begin
        r = r - (16'(SYMBOL_COUNT) << k);
      end
    end
    return r[SYM_W-1:0];
  endfunction

  // Pipeline control and payload.
  logic             s1_v_r, s2_v_r, s3_v_r;
  swad_pkg::op_t    s1_op_r, s2_op_r, s3_op_r;
  logic [SYM_W-1:0] s1_sym_r, s2_sym_r, s3_old_r;
  logic             s3_rem_r, s3_rej_r;
  logic             s1_mv, s2_mv, s3_done, in_accept;

  // Running state.
  logic [CNT_W-1:0]  plen_r, plen_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [DIFF_W-1:0] diff_r, diff_nxt;
  logic              found_r, found_nxt;
  logic              text_r, text_nxt;

  // History ring.
  logic [SYM_W-1:0] hist_mem [MAX_PATTERN];
  logic [SYM_W-1:0] hist_raw_r, hist_byp_r, hist_q;
  logic             hist_use_byp_r, hist_fwd;

  // Count store interface.
  swad_pkg::ram_cmd_t ram_cmd;
  logic [SYM_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data, a_q, b_q;

  // Entering step.
  logic [CNT_W-1:0]   a_p, a_w;
  logic               s2_wr, s2_inc, s2_dec, s2_rem, s2_rej, s2_clr;
  logic               s2_plen_inc, s2_hist_wr;
  logic [ENTRY_W-1:0] s2_wdata;
  logic [PTR_W:0]     ptr_inc;
  logic [PTR_W-1:0]   ptr_adv;

  // Leaving step.
  logic [CNT_W-1:0]   b_p, b_w, b_w2;
  logic [ENTRY_W-1:0] s3_wdata;
  logic [DIFF_W-1:0]  s3_diff;
  logic               s3_match;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  logic out_match_r, out_found_r, out_rej_r;

  // A word leaves the entering step only once the leaving step is empty,
  // so the count memory sees at most one write per edge.
  assign s3_done   = s3_v_r && (!out_valid_r || !out_stall);
  assign s2_mv     = s2_v_r && !s3_v_r;
  assign s1_mv     = s1_v_r && (!s2_v_r || s2_mv);
  assign in_stall  = s1_v_r && !s1_mv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_accept || (s1_v_r && !s1_mv);
      s2_v_r <= s1_mv || (s2_v_r && !s2_mv);
      s3_v_r <= s2_mv || (s3_v_r && !s3_done);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r  <= swad_pkg::op_t'(in_operation);
      s1_sym_r <= reduce_sym(in_symbol);
    end
    if (s1_mv) begin
      s2_op_r  <= s1_op_r;
      s2_sym_r <= s1_sym_r;
    end
    if (s2_mv) begin
      s3_op_r  <= s2_op_r;
      s3_old_r <= hist_q;
      s3_rem_r <= s2_rem;
      s3_rej_r <= s2_rej;
    end
  end

  // Entering step: count the new symbol, or the pattern byte.
  assign a_p     = a_q[ENTRY_W-1:CNT_W];
  assign a_w     = a_q[CNT_W-1:0];
  assign ptr_inc = {1'b0, ptr_r} + (PTR_W+1)'(1);
  assign ptr_adv = (CNT_W'(ptr_inc) >= plen_r) ? '0 : ptr_inc[PTR_W-1:0];

  always_comb begin
    s2_wr       = 1'b0;
    s2_inc      = 1'b0;
    s2_dec      = 1'b0;
    s2_rem      = 1'b0;
    s2_rej      = 1'b0;
    s2_clr      = 1'b0;
    s2_plen_inc = 1'b0;
    s2_hist_wr  = 1'b0;
    s2_wdata    = a_q;
    case (s2_op_r)
      swad_pkg::OP_CLEAR: begin
        s2_clr = 1'b1;
      end
      swad_pkg::OP_PATTERN: begin
        if (text_r || (plen_r >= CNT_W'(MAX_PATTERN))) begin
          s2_rej = 1'b1;
        end else begin
          s2_wr       = 1'b1;
          s2_wdata    = {a_p + CNT_W'(1), a_w};
          s2_inc      = (a_p == a_w);
          s2_dec      = ((a_p + CNT_W'(1)) == a_w);
          s2_plen_inc = 1'b1;
        end
      end
      swad_pkg::OP_TEXT: begin
        if (plen_r != '0) begin
          s2_wr      = 1'b1;
          s2_wdata   = {a_p, a_w + CNT_W'(1)};
          s2_inc     = (a_p == a_w);
          s2_dec     = (a_p == (a_w + CNT_W'(1)));
          s2_hist_wr = 1'b1;
          s2_rem     = (fill_r >= plen_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Leaving step: count out the oldest symbol and decide the match.
  assign b_p      = b_q[ENTRY_W-1:CNT_W];
  assign b_w      = b_q[CNT_W-1:0];
  assign b_w2     = (b_w != '0) ? (b_w - CNT_W'(1)) : b_w;
  assign s3_wdata = {b_p, b_w2};
  assign s3_diff  = s3_rem_r ?
                    (diff_r + DIFF_W'(b_p == b_w) - DIFF_W'(b_p == b_w2)) : diff_r;
  assign s3_match = (s3_op_r == swad_pkg::OP_TEXT) && (fill_r == plen_r) &&
                    (s3_diff == '0);

  always_comb begin
    plen_nxt  = plen_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    diff_nxt  = diff_r;
    found_nxt = found_r;
    text_nxt  = text_r;
    if (s2_mv) begin
      if (s2_clr) begin
        plen_nxt  = '0;
        fill_nxt  = '0;
        ptr_nxt   = '0;
        diff_nxt  = '0;
        found_nxt = 1'b0;
        text_nxt  = 1'b0;
      end else begin
        diff_nxt = diff_r + DIFF_W'(s2_inc) - DIFF_W'(s2_dec);
        if (s2_plen_inc) begin
          plen_nxt = plen_r + CNT_W'(1);
        end
        if (s2_op_r == swad_pkg::OP_TEXT) begin
          text_nxt = 1'b1;
        end
        if (s2_hist_wr) begin
          ptr_nxt = ptr_adv;
          if (!s2_rem) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
      end
    end else if (s3_done) begin
      diff_nxt  = s3_diff;
      found_nxt = found_r | s3_match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      fill_r  <= '0;
      ptr_r   <= '0;
      diff_r  <= '0;
      found_r <= 1'b0;
      text_r  <= 1'b0;
    end else begin
      plen_r  <= plen_nxt;
      fill_r  <= fill_nxt;
      ptr_r   <= ptr_nxt;
      diff_r  <= diff_nxt;
      found_r <= found_nxt;
      text_r  <= text_nxt;
    end
  end

  // The oldest symbol is fetched at the slot the pointer will hold after this
  // edge; with a one-byte pattern that slot is the one being written now.
  assign hist_fwd = s2_mv && s2_hist_wr && (ptr_nxt == ptr_r);
  assign hist_q   = hist_use_byp_r ? hist_byp_r : hist_raw_r;

  always_ff @(posedge clk) begin
    if (s2_mv && s2_hist_wr) begin
      hist_mem[ptr_r] <= s2_sym_r;
    end
    if (s1_mv) begin
      hist_raw_r <= hist_mem[ptr_nxt];
      hist_byp_r <= s2_sym_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_use_byp_r <= 1'b0;
    end else if (s1_mv) begin
      hist_use_byp_r <= hist_fwd;
    end
  end

  // Count store commands.
  always_comb begin
    ram_cmd.rd_a = s1_mv;
    ram_cmd.rd_b = s2_mv && s2_rem;
    ram_cmd.clr  = s2_mv && s2_clr;
    ram_cmd.wr   = (s2_mv && s2_wr) || (s3_done && s3_rem_r);
    if (s2_mv) begin
      wr_addr = s2_sym_r;
      wr_data = s2_wdata;
    end else begin
      wr_addr = s3_old_r;
      wr_data = s3_wdata;
    end
  end

  swad_count_ram #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .CNT_W        (CNT_W)
  ) u_count_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ram_cmd),
    .a_addr  (s1_sym_r),
    .b_addr  (hist_q),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .a_q     (a_q),
    .b_q     (b_q)
  );

  // Output register.
  assign out_valid_nxt = s3_done || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_done) begin
      out_match_r <= s3_match;
      out_found_r <= found_r | s3_match | (plen_r == '0);
      out_rej_r   <= s3_rej_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_match = out_match_r;
  assign out_found        = out_found_r;
  assign out_rejected     = out_rej_r;

endmodule
`default_nettype wire

// ----- rtl/swad_count_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swad_count_ram
// Per-symbol pattern and window counts in one synchronous memory with two
// registered read ports and one write port. Entry valid bits let one clear
// command empty the store; reads forward a write or clear on the same edge.
// ----------------------------------------------------------------------------
module swad_count_ram #(
  parameter int SYMBOL_COUNT = 256,
  parameter int CNT_W        = 11
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  swad_pkg::ram_cmd_t               cmd,
  input  wire [$clog2(SYMBOL_COUNT)-1:0]   a_addr,
  input  wire [$clog2(SYMBOL_COUNT)-1:0]   b_addr,
  input  wire [$clog2(SYMBOL_COUNT)-1:0]   wr_addr,
  input  wire [2*CNT_W-1:0]                wr_data,
  output logic [2*CNT_W-1:0]               a_q,
  output logic [2*CNT_W-1:0]               b_q
);

  localparam int SYM_W   = $clog2(SYMBOL_COUNT);
  localparam int ENTRY_W = 2 * CNT_W;

  logic [ENTRY_W-1:0]      mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_r;

  logic [ENTRY_W-1:0] a_raw_r, b_raw_r;
  logic [ENTRY_W-1:0] a_byp_r, b_byp_r;
  logic               a_use_byp_r, b_use_byp_r;
  logic [SYM_W-1:0]   a_addr_r;

  logic               a_hit, b_hit;
  logic               a_fwd_use, b_fwd_use;
  logic [ENTRY_W-1:0] a_fwd_data, b_fwd_data;

  assign a_hit      = cmd.wr && (wr_addr == a_addr);
  assign b_hit      = cmd.wr && (wr_addr == b_addr);
  assign a_fwd_use  = cmd.clr || a_hit || !valid_r[a_addr];
  assign b_fwd_use  = cmd.clr || b_hit || !valid_r[b_addr];
  assign a_fwd_data = (cmd.clr || !a_hit) ? '0 : wr_data;
  assign b_fwd_data = (cmd.clr || !b_hit) ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_a) begin
      a_raw_r <= mem[a_addr];
    end
    if (cmd.rd_b) begin
      b_raw_r <= mem[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clr) begin
      valid_r <= '0;
    end else if (cmd.wr) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Port A data may be held for a while before use, so it follows any later
  // write or clear that lands on its entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_use_byp_r <= 1'b0;
    end else if (cmd.rd_a) begin
      a_use_byp_r <= a_fwd_use;
    end else if (cmd.clr || (cmd.wr && (wr_addr == a_addr_r))) begin
      a_use_byp_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_a) begin
      a_byp_r  <= a_fwd_data;
      a_addr_r <= a_addr;
    end else if (cmd.clr) begin
      a_byp_r <= '0;
    end else if (cmd.wr && (wr_addr == a_addr_r)) begin
      a_byp_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_use_byp_r <= 1'b0;
    end else if (cmd.rd_b) begin
      b_use_byp_r <= b_fwd_use;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_b) begin
      b_byp_r <= b_fwd_data;
    end
  end

  assign a_q = a_use_byp_r ? a_byp_r : a_raw_r;
  assign b_q = b_use_byp_r ? b_byp_r : b_raw_r;

endmodule
`default_nettype wire

// ----- rtl/swad_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swad_checker
// Port-level checks on the anagram detector, bound to the top level.
// ----------------------------------------------------------------------------
module swad_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire       out_window_match,
  input wire       out_found,
  input wire       out_rejected
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_window_match) &&
    $stable(out_found) && $stable(out_rejected))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input side is ready as soon as reset has been seen.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // A match always implies the sticky flag.
  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_match |-> out_found)
    else $error("match without found");

  // A rejected pattern word never reports a match.
  a_reject_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> !out_window_match)
    else $error("rejected word reported a match");

endmodule

bind sliding_window_anagram_detector_unit swad_checker u_swad_checker (.*);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for sliding_window_anagram_detector_unit
// Feeds clear, pattern, text and unused-code words through the input channel
// under random idling on both sides. A local histogram model predicts the
// match, found and rejected flags of every word, and each result is compared
// with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_PATTERN  = 1024;
  localparam int SYMBOL_COUNT = 256;
  localparam int RANDOM_WORDS = 675;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    swad_pkg::op_t op;
    logic [7:0]    symbol;
  } word_t;

  typedef struct packed {
    logic window_match;
    logic found;
    logic rejected;
  } flags_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation = swad_pkg::OP_IDLE;
  logic [7:0] in_symbol = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_window_match;
  logic       out_found;
  logic       out_rejected;

  word_t  pending_words[$];
  flags_t expected_flags[$];
  int     total_words;
  int     accepted_words;
  int     checked_words;
  int     matches_seen;
  int     rejects_seen;
  int     errors;
  int     cycles;

  // Histogram model of the detector.
  bit   [10:0] pattern_hist[SYMBOL_COUNT];
  bit   [10:0] window_hist[SYMBOL_COUNT];
  logic [7:0]  history[MAX_PATTERN];
  bit   [10:0] pattern_len;
  bit   [10:0] window_fill;
  bit   [9:0]  ring_ptr;
  bit   [8:0]  differing;
  bit          found_seen;
  bit          text_seen;

  sliding_window_anagram_detector_unit #(
    .MAX_PATTERN (MAX_PATTERN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_window_match(out_window_match),
    .out_found       (out_found),
    .out_rejected    (out_rejected)
  );

  always #10 clk = ~clk;

  // A symbol whose counts are about to change is taken as differing; it is
  // taken off again if the counts agree after the change.
  function automatic void assume_differs(input logic [7:0] s);
    if (pattern_hist[s] == window_hist[s]) differing++;
  endfunction

  function automatic void confirm_balance(input logic [7:0] s);
    if (pattern_hist[s] == window_hist[s]) differing--;
  endfunction

  function automatic flags_t detector_step(input swad_pkg::op_t op, input logic [7:0] s);
    flags_t     res;
    int         slot;
    int         nxt;
    logic [7:0] old;
    res = '0;
    case (op)
      swad_pkg::OP_CLEAR: begin
        foreach (pattern_hist[i]) begin
          pattern_hist[i] = '0;
          window_hist[i] = '0;
        end
        pattern_len = '0;
        window_fill = '0;
        ring_ptr = '0;
        differing = '0;
        found_seen = 1'b0;
        text_seen = 1'b0;
      end
      swad_pkg::OP_PATTERN: begin
        if (text_seen || pattern_len >= MAX_PATTERN) begin
          res.rejected = 1'b1;
        end else begin
          assume_differs(s);
          pattern_hist[s]++;
          confirm_balance(s);
          pattern_len++;
        end
      end
      swad_pkg::OP_TEXT: begin
        text_seen = 1'b1;
        if (pattern_len != 0) begin
          slot = ring_ptr;
          assume_differs(s);
          window_hist[s]++;
          confirm_balance(s);
          if (window_fill >= pattern_len) begin
            old = history[slot];
            assume_differs(old);
            if (window_hist[old] != 0) window_hist[old]--;
            confirm_balance(old);
          end else begin
            window_fill++;
          end
          history[slot] = s;
          nxt = slot + 1;
          if (nxt >= pattern_len) nxt = 0;
          ring_ptr = nxt[9:0];
        end
        if (window_fill == pattern_len && differing == 0) begin
          res.window_match = 1'b1;
          found_seen = 1'b1;
        end
      end
      default: ;
    endcase
    res.found = found_seen || (pattern_len == 0);
    return res;
  endfunction

  function automatic void push_word(input swad_pkg::op_t op, input logic [7:0] s);
    word_t w;
    w.op = op;
    w.symbol = s;
    pending_words.push_back(w);
  endfunction

  // A narrow alphabet of four neighbouring symbols makes matches likely.
  function automatic logic [7:0] pick_symbol(input bit narrow, input logic [7:0] base);
    logic [7:0] s;
    if (narrow) s = base + 8'($urandom_range(0, 3));
    else s = 8'($urandom);
    return s;
  endfunction

  // Driver: a new word is offered only once the previous one has been taken.
  always @(posedge clk) begin
    int phase;
    int idle_pct;
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_flags.push_back(detector_step(swad_pkg::op_t'(in_operation), in_symbol));
        accepted_words++;
      end
      if (!in_valid || !in_stall) begin
        phase = (total_words > 0) ? accepted_words * 3 / total_words : 0;
        case (phase)
          0:       idle_pct = 24;
          1:       idle_pct = 65;
          default: idle_pct = 0;
        endcase
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_operation <= w.op;
          in_symbol <= w.symbol;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every taken result word and stalls the output at random.
  always @(posedge clk) begin
    int phase;
    int stall_pct;
    flags_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_flags.size() == 0) begin
          $error("result word with no prediction waiting: match %0b found %0b rejected %0b",
                 out_window_match, out_found, out_rejected);
          errors++;
        end else begin
          want = expected_flags.pop_front();
          if (out_window_match !== want.window_match) begin
            $error("window_match: expected %0b, got %0b", want.window_match, out_window_match);
            errors++;
          end
          if (out_found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_found);
            errors++;
          end
          if (out_rejected !== want.rejected) begin
            $error("rejected: expected %0b, got %0b", want.rejected, out_rejected);
            errors++;
          end
          checked_words++;
          if (want.window_match) matches_seen++;
          if (want.rejected) rejects_seen++;
        end
      end
    end
    phase = (total_words > 0) ? accepted_words * 3 / total_words : 0;
    case (phase)
      0:       stall_pct = 65;
      1:       stall_pct = 24;
      default: stall_pct = 0;
    endcase
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sliding_window_anagram_detector_unit: mismatch");
      $finish;
    end
  end

  initial begin
    logic [7:0] pat[];
    logic [7:0] tmp;
    logic [7:0] base;
    int         start;
    int         len;
    int         r;
    int         j;
    bit         narrow;

    // Directed words: empty pattern, extreme symbols, the unused code,
    // a window that is not yet full, and pattern words after text.
    push_word(swad_pkg::OP_IDLE, 8'h00);
    push_word(swad_pkg::OP_TEXT, 8'hFF);
    push_word(swad_pkg::OP_PATTERN, 8'h00);
    push_word(swad_pkg::OP_CLEAR, 8'hA5);
    push_word(swad_pkg::OP_PATTERN, 8'h00);
    push_word(swad_pkg::OP_PATTERN, 8'hFF);
    push_word(swad_pkg::OP_PATTERN, 8'h00);
    push_word(swad_pkg::OP_IDLE, 8'hFF);
    push_word(swad_pkg::OP_TEXT, 8'hFF);
    push_word(swad_pkg::OP_TEXT, 8'h00);
    push_word(swad_pkg::OP_TEXT, 8'h00);
    push_word(swad_pkg::OP_TEXT, 8'h5A);
    push_word(swad_pkg::OP_PATTERN, 8'hFF);
    push_word(swad_pkg::OP_TEXT, 8'h00);
    push_word(swad_pkg::OP_TEXT, 8'hFF);
    push_word(swad_pkg::OP_TEXT, 8'h00);
    push_word(swad_pkg::OP_IDLE, 8'h81);
    push_word(swad_pkg::OP_CLEAR, 8'h00);
    push_word(swad_pkg::OP_TEXT, 8'h80);
    push_word(swad_pkg::OP_CLEAR, 8'hFF);
    push_word(swad_pkg::OP_PATTERN, 8'h7F);
    push_word(swad_pkg::OP_TEXT, 8'h7F);
    push_word(swad_pkg::OP_TEXT, 8'h80);

    // Random sequences: mostly clear, short pattern, then text with shuffled
    // copies of the pattern among noise.
    start = pending_words.size();
    while (pending_words.size() - start < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) != 0) push_word(swad_pkg::OP_CLEAR, 8'($urandom));
      r = $urandom_range(0, 99);
      if (r < 5) len = 0;
      else if (r < 10) len = $urandom_range(7, 40);
      else len = $urandom_range(1, 6);
      narrow = ($urandom_range(0, 9) < 7);
      base = 8'($urandom);
      pat = new[len];
      foreach (pat[i]) begin
        pat[i] = pick_symbol(narrow, base);
        push_word(swad_pkg::OP_PATTERN, pat[i]);
      end
      repeat ($urandom_range(2, 6)) begin
        r = $urandom_range(0, 99);
        if (r < 45 && len > 0) begin
          for (int i = len - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = pat[i];
            pat[i] = pat[j];
            pat[j] = tmp;
          end
          foreach (pat[i]) push_word(swad_pkg::OP_TEXT, pat[i]);
        end else if (r < 85) begin
          repeat ($urandom_range(1, len + 2))
            push_word(swad_pkg::OP_TEXT, pick_symbol(narrow, base));
        end else if (r < 92) begin
          push_word(swad_pkg::OP_PATTERN, 8'($urandom));
        end else begin
          push_word(swad_pkg::OP_IDLE, 8'($urandom));
        end
      end
    end
    total_words = pending_words.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_flags.size() != 0) begin
      $error("%0d predicted result words never arrived", expected_flags.size());
      errors++;
    end
    $display("Ran %0d words through three idling phases, with directed corner cases first.",
             total_words);
    $display("Checked %0d result words: %0d window matches, %0d refused pattern words.",
             checked_words, matches_seen, rejects_seen);
    if (errors == 0) begin
      $display("sliding_window_anagram_detector_unit: match");
    end else begin
      $display("sliding_window_anagram_detector_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/swad_pkg.sv
rtl/swad_count_ram.sv
rtl/sliding_window_anagram_detector_unit.sv
rtl/swad_checker.sv
tb/sv/testbench.sv
